[rtl/multi_stack_lifo_engine_top_defines.svh]
// Assertion macros for the checker file of the stack engine.
`ifndef MULTI_STACK_LIFO_ENGINE_TOP_DEFINES_SVH
`define MULTI_STACK_LIFO_ENGINE_TOP_DEFINES_SVH

// Checked on every clock edge, reset included.
`define MSLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define MSLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[rtl/msle_pkg.sv]
// Shared types and constants of the multi-stack LIFO engine.
`timescale 1ns / 1ps
`default_nettype none
package msle_pkg;

    localparam int NUM_STACKS_DEF    = 8;
    localparam int MAX_DEPTH_DEF     = 16;
    localparam int ELEMENT_WIDTH_DEF = 32;

    localparam int REG_COUNT = 8;
    localparam int CAP_W     = 5;
    localparam int SEL_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_FULL     = 2'd1,
        ERR_EMPTY    = 2'd2,
        ERR_NO_STACK = 2'd3
    } t_err;

    // Result stage contents, waiting for the store read to come back.
    typedef struct packed {
        logic               use_push;
        logic               empty;
        logic               full;
        t_err               err;
        logic [VALUE_W-1:0] value;
    } t_res;

endpackage
`default_nettype wire

[rtl/msle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module msle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[rtl/multi_stack_lifo_engine_top.sv]
// The result appears on the master side in the cycle after its input transfer.
// One item per cycle while the master side does not stall; the shared store has one write and one read port.
// The input side takes an item whenever the result register is empty or being drained.
// Reset (synchronous, active low) clears counts, capacities and the result valid;
// the element store is not cleared and is read only at entries pushes have written.
`timescale 1ns / 1ps
`default_nettype none
module multi_stack_lifo_engine_top #(
    parameter int NUM_STACKS    = msle_pkg::NUM_STACKS_DEF,
    parameter int MAX_DEPTH     = msle_pkg::MAX_DEPTH_DEF,
    parameter int ELEMENT_WIDTH = msle_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // slave side
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [31:0]                 i_s_axis_tdata,  // [31:0] push_value
    input  wire logic [4:0]                  i_s_axis_tuser,  // [1:0] command, [4:2] stack_select
    // master side
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic [31:0]                      o_m_axis_tdata,  // [31:0] top_value
    output logic [3:0]                       o_m_axis_tuser,  // [0] empty_flag, [1] full_flag,
                                                              // [3:2] error_code
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [msle_pkg::APB_AW-1:0] paddr,
    input  wire logic [msle_pkg::APB_DW-1:0] pwdata,
    output logic      [msle_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);

    localparam int CNT_W       = $clog2(MAX_DEPTH + 1);
    localparam int EXT_W       = (CNT_W > msle_pkg::CAP_W) ? CNT_W : msle_pkg::CAP_W;
    localparam int SW          = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int STORE_DEPTH = NUM_STACKS * MAX_DEPTH;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Capacity register clipped to the physical depth of a stack.
    function automatic logic [CNT_W-1:0] eff_cap(input logic [msle_pkg::CAP_W-1:0] c);
        logic [EXT_W-1:0] c_ext;
        logic [EXT_W-1:0] d_ext;
        c_ext = EXT_W'(c);
        d_ext = EXT_W'(MAX_DEPTH);
        return (c_ext > d_ext) ? CNT_W'(d_ext) : CNT_W'(c_ext);
    endfunction

    function automatic logic [AW-1:0] store_addr(input logic [SW-1:0] s,
                                                 input logic [CNT_W-1:0] idx);
        return AW'(32'(s) * 32'(MAX_DEPTH) + 32'(idx));
    endfunction

    logic [msle_pkg::CAP_W-1:0] r_cap   [msle_pkg::REG_COUNT];
    logic [CNT_W-1:0]           r_count [NUM_STACKS];
    logic [CNT_W-1:0]           n_count [NUM_STACKS];
    logic                       r_res_valid;
    msle_pkg::t_res             r_res;
    msle_pkg::t_res             n_res;

    msle_pkg::t_cmd              w_cmd;
    logic [msle_pkg::SEL_W-1:0]  w_sel;
    logic                        w_sel_ok;
    logic [SW-1:0]               w_sidx;
    logic [CNT_W-1:0]            w_cap;
    logic                        w_created;
    logic [CNT_W-1:0]            w_cnt;
    logic [CNT_W-1:0]            w_new;
    msle_pkg::t_err              w_err;
    logic                        w_push_ok;
    logic                        w_accept;
    logic                        w_wr_en;
    logic [AW-1:0]               w_wr_addr;
    logic                        w_rd_en;
    logic [AW-1:0]               w_rd_addr;
    logic signed [ELEMENT_WIDTH-1:0] w_elem;
    logic signed [63:0]          w_elem_ext;
    logic [ELEMENT_WIDTH-1:0]    w_rd_data;
    logic signed [63:0]          w_rd_ext;
    logic                        w_cfg_wr;
    logic [msle_pkg::SEL_W-1:0]  w_widx;
    logic                        w_widx_ok;
    logic [SW-1:0]               w_wsidx;
    logic [CNT_W-1:0]            w_wcap;

    assign o_s_axis_tready = !r_res_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_cmd    = msle_pkg::t_cmd'(i_s_axis_tuser[1:0]);
    assign w_sel    = i_s_axis_tuser[4:2];
    assign w_sel_ok = 4'(w_sel) < 4'(NUM_STACKS);
    assign w_sidx   = w_sel_ok ? SW'(w_sel) : '0;
    assign w_cap    = eff_cap(r_cap[w_sel]);
    assign w_cnt    = r_count[w_sidx];
    assign w_created = w_sel_ok && (w_cap != '0);

    always_comb begin
        w_new     = w_cnt;
        w_err     = msle_pkg::ERR_OK;
        w_push_ok = 1'b0;
        unique case (w_cmd)
            msle_pkg::CMD_PUSH: begin
                if (w_cnt >= w_cap) begin
                    w_err = msle_pkg::ERR_FULL;
                end else begin
                    w_new     = w_cnt + 1'b1;
                    w_push_ok = 1'b1;
                end
            end
            msle_pkg::CMD_POP: begin
                if (w_cnt == '0) begin
                    w_err = msle_pkg::ERR_EMPTY;
                end else begin
                    w_new = w_cnt - 1'b1;
                end
            end
            default: begin
                // peek, and the unused code behaves the same
                if (w_cnt == '0) begin
                    w_err = msle_pkg::ERR_EMPTY;
                end
            end
        endcase
    end

    // Pushed value is cut to the element width and read back sign-extended.
    assign w_elem     = ELEMENT_WIDTH'(signed'(i_s_axis_tdata));
    assign w_elem_ext = 64'(w_elem);

    assign w_wr_en   = w_accept && w_created && w_push_ok;
    assign w_wr_addr = store_addr(w_sidx, w_cnt);
    assign w_rd_en   = w_accept && w_created && !w_push_ok && (w_new != '0);
    assign w_rd_addr = store_addr(w_sidx, w_new - 1'b1);

    msle_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_elem),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        if (w_created) begin
            n_res.use_push = w_push_ok;
            n_res.empty    = (w_new == '0);
            n_res.full     = (w_new == w_cap);
            n_res.err      = w_err;
        end else begin
            n_res.use_push = 1'b0;
            n_res.empty    = 1'b1;
            n_res.full     = 1'b0;
            n_res.err      = msle_pkg::ERR_NO_STACK;
        end
        n_res.value = w_elem_ext[31:0];
    end

    // Configuration writes, with the count clamped to a lowered capacity.
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_widx    = paddr[msle_pkg::APB_AW-1:2];
    assign w_widx_ok = 4'(w_widx) < 4'(NUM_STACKS);
    assign w_wsidx   = w_widx_ok ? SW'(w_widx) : '0;
    assign w_wcap    = eff_cap(pwdata[msle_pkg::CAP_W-1:0]);

    always_comb begin
        n_count = r_count;
        if (w_accept && w_created) begin
            n_count[w_sidx] = w_new;
        end
        if (w_cfg_wr && w_widx_ok && (n_count[w_wsidx] > w_wcap)) begin
            n_count[w_wsidx] = w_wcap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < msle_pkg::REG_COUNT; i++) begin
                r_cap[i] <= '0;
            end
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_count[i] <= '0;
            end
            r_res_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_cap[w_widx] <= pwdata[msle_pkg::CAP_W-1:0];
            end
            r_count <= n_count;
            if (o_s_axis_tready) begin
                r_res_valid <= i_s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign pready = 1'b1;
    assign prdata = msle_pkg::APB_DW'(r_cap[w_widx]);

    assign w_rd_ext        = 64'(signed'(w_rd_data));
    assign o_m_axis_tvalid = r_res_valid;
    assign o_m_axis_tdata  = r_res.empty    ? '0 :
                             r_res.use_push ? r_res.value : w_rd_ext[31:0];
    assign o_m_axis_tuser  = {r_res.err, r_res.full, r_res.empty};

endmodule
`default_nettype wire

[rtl/msle_checker.sv]
// Port-level checker for the stack engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_stack_lifo_engine_top_defines.svh"
module msle_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_pready,
    input wire logic        i_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] i_m_axis_tdata,
    input wire logic [3:0]  i_m_axis_tuser
);

    logic [1:0] w_err;
    assign w_err = i_m_axis_tuser[3:2];

    `MSLE_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !i_m_axis_tvalid && i_pready, "result valid or pready wrong after reset")

    `MSLE_ASSERT(a_no_stack, i_clk, i_rst_n, i_m_axis_tvalid && (w_err == 2'(msle_pkg::ERR_NO_STACK)) |-> i_m_axis_tuser[0] && !i_m_axis_tuser[1], "missing stack result has wrong flags")

    `MSLE_ASSERT(a_empty_zero, i_clk, i_rst_n, i_m_axis_tvalid && (i_m_axis_tuser[0] || (w_err == 2'(msle_pkg::ERR_EMPTY))) |-> i_m_axis_tuser[0] && (i_m_axis_tdata == 32'd0), "empty result with nonzero top")

    `MSLE_ASSERT(a_full_err, i_clk, i_rst_n, i_m_axis_tvalid && (w_err == 2'(msle_pkg::ERR_FULL)) |-> i_m_axis_tuser[1] && !i_m_axis_tuser[0], "push error without full flag")

    `MSLE_ASSERT(a_stall_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser), "stalled result changed")

endmodule

bind multi_stack_lifo_engine_top msle_checker u_msle_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_pready        (pready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire

[bench/msle_result_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the stack engine: tracks capacities and stacks, checks every result transfer.
module msle_result_checker
    import msle_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_s_tready,
    input  wire logic [31:0]       i_s_tdata,   // [31:0] push_value
    input  wire logic [4:0]        i_s_tuser,   // [1:0] command, [4:2] stack_select
    input  wire logic              i_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire logic [31:0]       i_m_tdata,   // [31:0] top_value
    input  wire logic [3:0]        i_m_tuser,   // [0] empty, [1] full, [3:2] error_code
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic              i_pready,
    input  wire logic [APB_AW-1:0] i_paddr,
    input  wire logic [APB_DW-1:0] i_pwdata,
    output int                     o_pending,
    output int                     o_errors
);
    localparam int STACKS = NUM_STACKS_DEF;
    localparam int DEPTH  = MAX_DEPTH_DEF;

    typedef struct packed {
        logic [VALUE_W-1:0] top;
        logic               empty;
        logic               full;
        t_err               err;
    } t_stack_result;

    logic [VALUE_W-1:0] elem_mem  [STACKS*DEPTH];
    logic [CAP_W-1:0]   depth_cnt [STACKS];
    logic [CAP_W-1:0]   cap_reg   [REG_COUNT];
    t_stack_result      pending_results [$];
    int                 error_cnt = 0;

    assign o_errors = error_cnt;

    // Capacity registers above the store depth saturate.
    function automatic logic [CAP_W-1:0] usable_depth(int idx);
        if (cap_reg[idx] > DEPTH)
            return CAP_W'(DEPTH);
        return cap_reg[idx];
    endfunction

    function automatic t_stack_result predict_stack_op(logic [1:0] cmd,
                                                       logic [SEL_W-1:0] sel,
                                                       logic [VALUE_W-1:0] value);
        t_stack_result    res;
        logic [CAP_W-1:0] cap;
        logic [CAP_W-1:0] cnt;
        int               base;
        cap     = usable_depth(int'(sel));
        res.err = ERR_OK;
        if (cap == 0) begin
            res.top   = '0;
            res.empty = 1'b1;
            res.full  = 1'b0;
            res.err   = ERR_NO_STACK;
            return res;
        end
        base = int'(sel) * DEPTH;
        cnt  = depth_cnt[sel];
        if (cmd == CMD_PUSH) begin
            if (cnt >= cap) begin
                res.err = ERR_FULL;
            end else begin
                elem_mem[base + cnt] = value;
                cnt = cnt + 1'b1;
            end
        end else if (cmd == CMD_POP) begin
            if (cnt == 0)
                res.err = ERR_EMPTY;
            else
                cnt = cnt - 1'b1;
        end else if (cnt == 0) begin
            // peek and the spare code 3 behave alike
            res.err = ERR_EMPTY;
        end
        depth_cnt[sel] = cnt;
        res.top   = (cnt != 0) ? elem_mem[base + cnt - 1] : '0;
        res.empty = (cnt == 0);
        res.full  = (cnt == cap);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s: got %h, want %h", $time, what, got, want);
        error_cnt++;
    endtask

    always @(posedge i_clk) begin : watch
        t_stack_result    want;
        logic [2:0]       idx;
        if (!i_rst_n) begin
            for (int s = 0; s < STACKS; s++)
                depth_cnt[s] = '0;
            for (int r = 0; r < REG_COUNT; r++)
                cap_reg[r] = '0;
            pending_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                idx = i_paddr[APB_AW-1:2];
                cap_reg[idx] = i_pwdata[CAP_W-1:0];
                // lowering a capacity clamps the stack
                if (depth_cnt[idx] > usable_depth(int'(idx)))
                    depth_cnt[idx] = usable_depth(int'(idx));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result transfer with no request", i_m_tdata, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_m_tdata !== want.top)
                        report_mismatch("top_value", i_m_tdata, want.top);
                    if (i_m_tuser[0] !== want.empty)
                        report_mismatch("empty_flag", i_m_tuser[0], want.empty);
                    if (i_m_tuser[1] !== want.full)
                        report_mismatch("full_flag", i_m_tuser[1], want.full);
                    if (i_m_tuser[3:2] !== want.err)
                        report_mismatch("error_code", i_m_tuser[3:2], want.err);
                end
            end
            if (i_s_tvalid && i_s_tready)
                pending_results.push_back(predict_stack_op(i_s_tuser[1:0], i_s_tuser[4:2],
                                                           i_s_tdata));
        end
        o_pending <= pending_results.size();
    end

endmodule

[bench/tb_multi_stack_lifo_engine_top.sv]
`timescale 1ns / 1ps
// Testbench top for the stack engine: clock, reset, stimulus and verdict.
module tb_multi_stack_lifo_engine_top;
    import msle_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;   // unused code, acts as peek
    localparam int         PHASES    = 8;
    localparam int         PHASE_OPS = 230;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata = '0;   // [31:0] push_value
    logic [4:0]        s_tuser = '0;   // [1:0] command, [4:2] stack_select
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;        // [31:0] top_value
    logic [3:0]        m_tuser;        // [0] empty, [1] full, [3:2] error_code
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              long_hold_req = 1'b0;
    int                pending;
    int                errors;
    logic [CAP_W-1:0]  cap_shadow [REG_COUNT] = '{default: '0};

    multi_stack_lifo_engine_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    msle_result_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_pready   (pready),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb_multi_stack_lifo_engine_top: errors");
        $finish;
    end

    // Offer one item and hold it until the transfer.
    task automatic send_item(logic [1:0] cmd, logic [SEL_W-1:0] sel, logic [31:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= {sel, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_capacity(int idx, logic [CAP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        cap_shadow[idx] = value;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly stacks that exist; now and then any index.
    function automatic logic [SEL_W-1:0] pick_stack();
        int live [$];
        for (int s = 0; s < REG_COUNT; s++)
            if (cap_shadow[s] != 0)
                live.push_back(s);
        if (live.size() == 0 || $urandom_range(0, 99) < 15)
            return SEL_W'($urandom_range(0, 7));
        return SEL_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    function automatic logic [1:0] pick_command(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return CMD_SPARE;
        if (r < push_pct)
            return CMD_PUSH;
        if (r < push_pct + (100 - push_pct) * 2 / 3)
            return CMD_POP;
        return CMD_PEEK;
    endfunction

    // Result side: segments of different stall patterns, one long hold-off on request.
    initial begin : result_sink
        int mode;
        int seg;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(20, 200);
            for (int k = 0; k < seg; k++) begin
                if (long_hold_req && !hold_done) begin
                    m_tready <= 1'b0;
                    repeat (60) @(posedge clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ((k % 4) != 3);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int               push_pct;
        int               burst;
        int               gap;
        int               issued;
        logic [CAP_W-1:0] c;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing created yet
        send_item(CMD_PUSH, 3'd0, 32'h1234_5678);
        send_item(CMD_PEEK, 3'd7, 32'h0);
        drain();
        set_capacity(0, 5'd1);
        set_capacity(1, 5'd16);
        set_capacity(2, 5'd31);

        // single-entry stack: full, overflow, underflow, empty peek; then stack 1, missing stack 3 and clipped stack 2
        send_item(CMD_PUSH, 3'd0, 32'h7FFF_FFFF);
        send_item(CMD_PUSH, 3'd0, 32'h0000_0001);
        send_item(CMD_PEEK, 3'd0, 32'hFFFF_FFFF);
        send_item(CMD_POP, 3'd0, 32'h0);
        send_item(CMD_POP, 3'd0, 32'h0);
        send_item(CMD_PEEK, 3'd0, 32'h0);
        send_item(CMD_SPARE, 3'd0, 32'h0);
        send_item(CMD_PUSH, 3'd1, 32'h8000_0000);
        send_item(CMD_PUSH, 3'd1, 32'hFFFF_FFFF);
        send_item(CMD_PUSH, 3'd1, 32'h0000_0000);
        send_item(CMD_PUSH, 3'd1, 32'h55AA_55AA);
        send_item(CMD_SPARE, 3'd1, 32'h0);
        send_item(CMD_POP, 3'd1, 32'hAAAA_AAAA);
        send_item(CMD_PUSH, 3'd3, 32'h0F0F_0F0F);
        send_item(CMD_PUSH, 3'd2, 32'hDEAD_BEEF);
        drain();

        // shrink below the count: stack 1 keeps its bottom entry only
        set_capacity(1, 5'd1);
        send_item(CMD_PEEK, 3'd1, 32'h0);
        send_item(CMD_POP, 3'd1, 32'h0);
        drain();

        // removing a stack empties it
        set_capacity(2, 5'd0);
        set_capacity(2, 5'd16);
        send_item(CMD_PEEK, 3'd2, 32'h0);
        send_item(CMD_PUSH, 3'd2, 32'hA5A5_A5A5);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            for (int s = 0; s < REG_COUNT; s++) begin
                case ($urandom_range(0, 7))
                    0:       c = 5'd0;
                    1:       c = 5'd1;
                    2:       c = 5'd16;
                    3:       c = CAP_W'($urandom_range(17, 31));
                    default: c = CAP_W'($urandom_range(2, 15));
                endcase
                if (phase == 0)
                    c = 5'd16;
                else if (phase == PHASES - 1)
                    c = (s % 4 == 0) ? 5'd0 : (s % 4 == 1) ? 5'd1 :
                        (s % 4 == 2) ? 5'd31 : 5'd16;
                set_capacity(s, c);
            end
            push_pct = (phase == 0) ? 80 : $urandom_range(30, 80);
            if (phase == 1)
                long_hold_req <= 1'b1;
            issued = 0;
            while (issued < PHASE_OPS) begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && issued < PHASE_OPS; k++) begin
                    send_item(pick_command(push_pct), pick_stack(), pick_value());
                    issued++;
                end
                gap = (phase % 3 == 2) ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        drain();
        repeat (5) @(posedge clk);
        if (errors == 0) begin
            $display("tb_multi_stack_lifo_engine_top: clean");
        end else begin
            $display("tb_multi_stack_lifo_engine_top: errors");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/msle_pkg.sv
rtl/msle_ram.sv
rtl/multi_stack_lifo_engine_top.sv
rtl/msle_checker.sv
bench/msle_result_checker.sv
bench/tb_multi_stack_lifo_engine_top.sv
